@@ hw/rtl/tab_expanding_row_renderer_macros.svh @@
// ----------------------------------------------------------------------------
// tab expanding row renderer assertion macros
// shared property forms, clocked on clk and disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TAB_EXPANDING_ROW_RENDERER_MACROS_SVH
`define TAB_EXPANDING_ROW_RENDERER_MACROS_SVH

// same-cycle implication
`define TRER_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TRER_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/trer_pkg.sv @@
// ----------------------------------------------------------------------------
// trer_pkg
// types and constants shared by the tab expanding row renderer
// ----------------------------------------------------------------------------
`default_nettype none

package trer_pkg;

    localparam int COL_W       = 17;
    localparam int DIV_CNT_W   = 5;
    localparam int QUEUE_DEPTH = 2;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [DIV_CNT_W-1:0] DIV_TOP = DIV_CNT_W'(COL_W - 1);

    // input kind codes
    localparam logic [1:0] KIND_ROW_START = 2'd0;
    localparam logic [1:0] KIND_CHAR      = 2'd1;
    localparam logic [1:0] KIND_ROW_END   = 2'd2;
    localparam logic [1:0] KIND_RESERVED  = 2'd3;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_TAB_WIDTH    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_COLUMN = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_WIDTH = 2'd2;

    localparam logic [7:0]  TAB_CHAR  = 8'h09;
    localparam logic [7:0]  LF_CHAR   = 8'h0A;
    localparam logic [7:0]  CR_CHAR   = 8'h0D;
    localparam logic [31:0] NO_OFFSET = 32'hFFFF_FFFF;

    typedef enum logic [2:0] {
        CK_CHAR   = 3'd0,
        CK_TAB    = 3'd1,
        CK_TBEGIN = 3'd2,
        CK_TMID   = 3'd3,
        CK_TEND   = 3'd4,
        CK_WRAP   = 3'd5,
        CK_NONE   = 3'd6
    } cell_kind_t;

    typedef enum logic [1:0] {
        OP_START,
        OP_CHAR,
        OP_TAB,
        OP_END
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_TAB,
        ST_NONE
    } back_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  char_code;
        logic [31:0] text_offset;
        logic [15:0] start_col;
        logic        ends_text;
    } in_item_t;

    typedef struct packed {
        logic [9:0]  cell_index;
        cell_kind_t  cell_kind;
        logic [7:0]  cell_char;
        logic [31:0] cell_offset;
        logic        offset_valid;
        logic [10:0] run_length;
        logic        last;
    } out_item_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  char_code;
        logic [31:0] text_offset;
        logic [15:0] start_col;
        logic        ends_text;
        logic        is_crlf;
    } queue_item_t;

    typedef struct packed {
        logic [5:0]  tab_stop;
        logic [15:0] first_column;
        logic [10:0] window_width;
    } cfg_t;

endpackage

`default_nettype wire

@@ hw/rtl/trer_front.sv @@
// ----------------------------------------------------------------------------
// trer_front
// accepts input requests, sorts them into operations for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module trer_front
    import trer_pkg::*;
(
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire in_item_t    in_data,
    input  wire logic        queue_full,
    output logic             push,
    output queue_item_t      push_item
);

    logic keep;

    always_comb
    begin
        push_item.char_code   = in_data.char_code;
        push_item.text_offset = in_data.text_offset;
        push_item.start_col   = in_data.start_col;
        push_item.ends_text   = in_data.ends_text;
        push_item.is_crlf     = in_data.char_code inside {CR_CHAR, LF_CHAR};
        push_item.op          = OP_CHAR;
        keep                  = 1'b1;
        case (in_data.kind)
            KIND_ROW_START: push_item.op = OP_START;
            KIND_CHAR:      push_item.op = (in_data.char_code == TAB_CHAR) ? OP_TAB : OP_CHAR;
            KIND_ROW_END:   push_item.op = OP_END;
            default:        keep = 1'b0;    // reserved kind is dropped
        endcase
    end

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full && keep;

endmodule

`default_nettype wire

@@ hw/rtl/trer_queue.sv @@
// ----------------------------------------------------------------------------
// trer_queue
// short fifo of classified operations between front and back end
// ----------------------------------------------------------------------------
`default_nettype none

module trer_queue
    import trer_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    input  wire queue_item_t push_item,
    output logic             full,
    input  wire logic        pop,
    output queue_item_t      head,
    output logic             head_valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    queue_item_t       entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entry_reg[rd_ptr_reg];

endmodule

`default_nettype wire

@@ hw/rtl/trer_back.sv @@
// ----------------------------------------------------------------------------
// trer_back
// carries out queued operations: keeps the row column, expands tabs, emits cells
// ----------------------------------------------------------------------------
`default_nettype none

module trer_back
    import trer_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int MAX_TAB    = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire cfg_t        cfg,
    input  wire queue_item_t head,
    input  wire logic        head_valid,
    output logic             pop,
    output logic             out_valid,
    input  wire logic        out_ready,
    output out_item_t        out_data
);

    back_state_t           state_reg, state_next;
    logic [COL_W-1:0]      col_reg, col_next;
    logic                  prev_crlf_reg, prev_crlf_next;
    logic                  full_reg, full_next;
    logic [DIV_CNT_W-1:0]  div_cnt_reg, div_cnt_next;
    logic [6:0]            rem_reg, rem_next;
    logic [6:0]            tab_n_reg, tab_n_next;
    logic [6:0]            tab_i_reg, tab_i_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_data_reg;

    logic [COL_W-1:0]      win17, eff_w, first17, right_col, col_inc, none_col, none_run;
    logic [6:0]            tw_raw, eff_tw, trial, rem_step;
    logic                  at_full, visible, inc_full, slot_free, tab_last_i, emit;
    out_item_t             cell_out;

    // effective register values and row limits
    always_comb
    begin
        win17 = COL_W'(cfg.window_width);
        if (cfg.window_width == '0)
            eff_w = COL_W'(1);
        else if (win17 > COL_W'(MAX_WINDOW))
            eff_w = COL_W'(MAX_WINDOW);
        else
            eff_w = win17;

        tw_raw = 7'(cfg.tab_stop);
        if (cfg.tab_stop == '0)
            eff_tw = 7'd1;
        else if (tw_raw > 7'(MAX_TAB))
            eff_tw = 7'(MAX_TAB);
        else
            eff_tw = tw_raw;

        first17    = COL_W'(cfg.first_column);
        right_col  = first17 + eff_w;
        col_inc    = col_reg + COL_W'(1);
        at_full    = full_reg || (col_reg >= right_col);
        visible    = (col_reg >= first17);
        inc_full   = (col_inc >= right_col);
        slot_free  = !out_valid_reg || out_ready;
        tab_last_i = (tab_i_reg == tab_n_reg - 7'd1);
        none_col   = visible ? col_reg : first17;
        none_run   = right_col - none_col;

        // one remainder bit per cycle, column msb first
        trial    = {rem_reg[5:0], col_reg[div_cnt_reg]};
        rem_step = (trial >= eff_tw) ? trial - eff_tw : trial;
    end

    always_comb
    begin
        state_next     = state_reg;
        col_next       = col_reg;
        prev_crlf_next = prev_crlf_reg;
        full_next      = full_reg;
        div_cnt_next   = div_cnt_reg;
        rem_next       = rem_reg;
        tab_n_next     = tab_n_reg;
        tab_i_next     = tab_i_reg;
        pop            = 1'b0;
        emit           = 1'b0;

        cell_out.cell_index   = 10'(col_reg - first17);
        cell_out.cell_kind    = CK_CHAR;
        cell_out.cell_char    = 8'd0;
        cell_out.cell_offset  = head.text_offset;
        cell_out.offset_valid = 1'b1;
        cell_out.run_length   = 11'd1;
        cell_out.last         = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    case (head.op)
                        OP_START:
                        begin
                            col_next       = COL_W'(head.start_col);
                            prev_crlf_next = 1'b0;
                            full_next      = (COL_W'(head.start_col) >= right_col);
                            pop            = 1'b1;
                        end
                        OP_CHAR:
                        begin
                            if (at_full)
                            begin
                                full_next = 1'b1;
                                pop       = 1'b1;
                            end
                            else if (!visible || slot_free)
                            begin
                                emit               = visible;
                                cell_out.cell_char = head.char_code;
                                col_next           = col_inc;
                                full_next          = inc_full;
                                prev_crlf_next     = head.is_crlf;
                                pop                = 1'b1;
                            end
                        end
                        OP_TAB:
                        begin
                            if (at_full)
                            begin
                                full_next = 1'b1;
                                pop       = 1'b1;
                            end
                            else
                            begin
                                prev_crlf_next = 1'b0;
                                rem_next       = 7'd0;
                                div_cnt_next   = DIV_TOP;
                                state_next     = ST_DIV;
                            end
                        end
                        OP_END:
                        begin
                            if (at_full)
                            begin
                                full_next = 1'b1;
                                pop       = 1'b1;
                            end
                            else if (head.ends_text || prev_crlf_reg)
                            begin
                                state_next = ST_NONE;
                            end
                            else if (!visible || slot_free)
                            begin
                                // wrap marker, then the none fill if room is left
                                emit                  = visible;
                                cell_out.cell_kind    = CK_WRAP;
                                cell_out.cell_offset  = NO_OFFSET;
                                cell_out.offset_valid = 1'b0;
                                cell_out.last         = inc_full;
                                col_next              = col_inc;
                                if (inc_full)
                                begin
                                    full_next = 1'b1;
                                    pop       = 1'b1;
                                end
                                else
                                begin
                                    state_next = ST_NONE;
                                end
                            end
                        end
                        default:
                        begin
                            pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_DIV:
            begin
                rem_next     = rem_step;
                div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                if (div_cnt_reg == '0)
                begin
                    tab_n_next = eff_tw - rem_step;
                    tab_i_next = 7'd0;
                    state_next = ST_TAB;
                end
            end
            ST_TAB:
            begin
                if (!visible || slot_free)
                begin
                    emit = visible;
                    if (tab_n_reg == 7'd1)
                        cell_out.cell_kind = CK_TAB;
                    else if (tab_i_reg == 7'd0)
                        cell_out.cell_kind = CK_TBEGIN;
                    else if (tab_last_i)
                        cell_out.cell_kind = CK_TEND;
                    else
                        cell_out.cell_kind = CK_TMID;
                    cell_out.last = tab_last_i || inc_full;
                    col_next      = col_inc;
                    tab_i_next    = tab_i_reg + 7'd1;
                    if (inc_full)
                    begin
                        full_next = 1'b1;
                    end
                    if (tab_last_i || inc_full)
                    begin
                        pop        = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_NONE:
            begin
                if (slot_free)
                begin
                    emit                  = 1'b1;
                    cell_out.cell_index   = 10'(none_col - first17);
                    cell_out.cell_kind    = CK_NONE;
                    cell_out.cell_offset  = NO_OFFSET;
                    cell_out.offset_valid = 1'b0;
                    cell_out.run_length   = 11'(none_run);
                    col_next              = right_col;
                    full_next             = 1'b1;
                    pop                   = 1'b1;
                    state_next            = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        out_valid_next = emit || (out_valid_reg && !out_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            col_reg       <= '0;
            prev_crlf_reg <= 1'b0;
            full_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            prev_crlf_reg <= prev_crlf_next;
            full_reg      <= full_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_cnt_reg <= div_cnt_next;
        rem_reg     <= rem_next;
        tab_n_reg   <= tab_n_next;
        tab_i_reg   <= tab_i_next;
        if (emit)
        begin
            out_data_reg <= cell_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/tab_expanding_row_renderer.sv @@
// Tab expanding row renderer: turns a stream of row start, character and row end
// requests into display cells of a horizontally scrolled window. Requests enter a
// two-entry queue, so the input side keeps accepting requests while a result waits
// at the output register until the queue fills. Row starts and plain characters are
// handled in the idle state. A row end is classified there, with a wrap marker
// unless the text ends or follows a CR or LF, then gets the none fill, skipped if
// the row is already full or its wrap marker takes the last cell. A tab starts in
// the idle state, passes the serial remainder unit that finds the column within the
// tab stop, then takes one column per cycle while the output register is free, up
// to the next stop (at most the tab stop distance). A visible cell meeting a held
// output register stalls. A reserved kind is dropped at the input with no output.
`default_nettype none

`include "tab_expanding_row_renderer_macros.svh"

// ----------------------------------------------------------------------------
// tab_expanding_row_renderer
// top level: configuration registers, front end, queue and back end
// ----------------------------------------------------------------------------
module tab_expanding_row_renderer
    import trer_pkg::*;
#(
    parameter int MAX_WINDOW = 1024,
    parameter int MAX_TAB    = 32
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire in_item_t               in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output out_item_t                   out_data,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t        cfg_reg;
    logic        queue_full;
    logic        push;
    queue_item_t push_item;
    logic        pop;
    queue_item_t head;
    logic        head_valid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tab_stop     <= 6'd8;
            cfg_reg.first_column <= 16'd0;
            cfg_reg.window_width <= 11'd80;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TAB_WIDTH:    cfg_reg.tab_stop     <= cfg_data[5:0];
                CFG_FIRST_COLUMN: cfg_reg.first_column <= cfg_data;
                CFG_WINDOW_WIDTH: cfg_reg.window_width <= cfg_data[10:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    trer_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    trer_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    trer_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_TAB    (MAX_TAB)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    `TRER_ASSERT_IMP(a_no_source_kind, out_valid && !out_data.offset_valid,
        out_data.cell_kind == CK_WRAP || out_data.cell_kind == CK_NONE,
        "cell without source is not wrap or none")
    `TRER_ASSERT_IMP(a_run_only_none, out_valid && out_data.run_length != 11'd1,
        out_data.cell_kind == CK_NONE, "run longer than one on a non-fill cell")
    `TRER_ASSERT_NXT(a_push_lands, in_valid && in_ready && in_data.kind != KIND_RESERVED,
        head_valid, "accepted request missing from queue")
    `TRER_ASSERT_IMP(a_pop_has_head, pop, head_valid, "back end popped an empty queue")

endmodule

`default_nettype wire
